// ===== design/kline_fast_init_polling_client_defines.svh =====
// Assertion macros used by the top-level client RTL file.
`ifndef KLINE_FAST_INIT_POLLING_CLIENT_DEFINES_SVH
`define KLINE_FAST_INIT_POLLING_CLIENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KFI_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KFI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KFI_ASSERT_IMPL(name, ante, cons, msg)
`define KFI_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== design/kfi_pkg.sv =====
package kfi_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int MAX_RES        = 8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    localparam logic [2:0] CFG_INIT_IDLE = 3'd0;
    localparam logic [2:0] CFG_PULSE     = 3'd1;
    localparam logic [2:0] CFG_WATCHDOG  = 3'd2;
    localparam logic [2:0] CFG_GAP       = 3'd3;
    localparam logic [2:0] CFG_ERR_LIMIT = 3'd4;

    localparam logic [15:0] INIT_IDLE_RST = 16'd6000;
    localparam logic [7:0]  PULSE_RST     = 8'd25;
    localparam logic [15:0] WATCHDOG_RST  = 16'd500;
    localparam logic [15:0] GAP_RST       = 16'd200;
    localparam logic [3:0]  ERR_LIMIT_RST = 4'd5;

    localparam logic [2:0] START_LEN = 3'd5;
    localparam logic [2:0] READ_LEN  = 3'd7;

    typedef enum logic [2:0] {
        KIND_STATUS = 3'd0,
        KIND_TX     = 3'd1,
        KIND_FRAME  = 3'd2,
        KIND_GOOD   = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        LINK_WAKE   = 2'd0,
        LINK_OPEN   = 2'd1,
        LINK_ACTIVE = 2'd2
    } link_t;

    typedef struct packed {
        logic [15:0] init_idle;
        logic [7:0]  pulse;
        logic [15:0] watchdog;
        logic [15:0] gap;
        logic [3:0]  error_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        entry_t [MAX_RES-1:0] entry;
        logic [3:0]           count;
        logic                 line_low;
        link_t                link_state;
        logic                 timed_out;
    } step_res_t;

    function automatic logic [7:0] req_byte(input logic active, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (active)
        begin
            case (idx)
                3'd0:    b = 8'h80;
                3'd1:    b = 8'h12;
                3'd2:    b = 8'hF1;
                3'd3:    b = 8'h02;
                3'd4:    b = 8'h21;
                3'd5:    b = 8'h08;
                3'd6:    b = 8'hAE;
                default: b = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    b = 8'h81;
                3'd1:    b = 8'h12;
                3'd2:    b = 8'hF1;
                3'd3:    b = 8'h81;
                3'd4:    b = 8'h05;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== design/kfi_core.sv =====
module kfi_core #(
    parameter int TIMER_BITS = kfi_pkg::TIMER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              cmd,
    input  logic [7:0]        rx_byte,
    input  kfi_pkg::cfg_t     cfg,
    output kfi_pkg::step_res_t res
);

    localparam int XW = (TIMER_BITS > 17) ? TIMER_BITS + 1 : 18;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    kfi_pkg::link_t         mode_reg, mode_next;
    logic [TIMER_BITS-1:0]  wake_reg, wake_next;
    logic [TIMER_BITS-1:0]  gap_reg, gap_next;
    logic [TIMER_BITS-1:0]  sil_reg, sil_next;
    logic                   skip_reg, skip_next;
    logic                   bst_reg, bst_next;
    logic [2:0]             sent_reg, sent_next;
    logic [8:0]             rc_reg, rc_next;
    logic [7:0]             fs_reg, fs_next;
    logic [7:0]             sum_reg, sum_next;
    logic [3:0]             bad_reg, bad_next;
    logic                   low_reg, low_next;

    logic [XW-1:0]          e_x, b1_x, b2_x, b3_x;
    logic [TIMER_BITS-1:0]  gap_inc, sil_inc;
    logic [2:0]             req_len, tx_n;
    logic [8:0]             rc_inc, diff;
    logic [7:0]             fsz;
    logic [9:0]             thr;
    logic [3:0]             bad_inc;
    logic [3:0]             n;
    logic                   good, timed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= kfi_pkg::LINK_WAKE;
            wake_reg <= '0;
            gap_reg  <= '0;
            sil_reg  <= '0;
            skip_reg <= 1'b0;
            bst_reg  <= 1'b0;
            sent_reg <= '0;
            rc_reg   <= '0;
            fs_reg   <= '0;
            sum_reg  <= '0;
            bad_reg  <= '0;
            low_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            wake_reg <= wake_next;
            gap_reg  <= gap_next;
            sil_reg  <= sil_next;
            skip_reg <= skip_next;
            bst_reg  <= bst_next;
            sent_reg <= sent_next;
            rc_reg   <= rc_next;
            fs_reg   <= fs_next;
            sum_reg  <= sum_next;
            bad_reg  <= bad_next;
            low_reg  <= low_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        wake_next = wake_reg;
        gap_next  = gap_reg;
        sil_next  = sil_reg;
        skip_next = skip_reg;
        bst_next  = bst_reg;
        sent_next = sent_reg;
        rc_next   = rc_reg;
        fs_next   = fs_reg;
        sum_next  = sum_reg;
        bad_next  = bad_reg;
        low_next  = low_reg;
        timed     = 1'b0;
        good      = 1'b0;
        n         = 4'd0;
        res       = '0;

        e_x  = XW'(wake_reg);
        b1_x = XW'(cfg.init_idle);
        b2_x = b1_x + XW'(cfg.pulse);
        b3_x = b2_x + XW'(cfg.pulse);

        gap_inc = (gap_reg == TMAX) ? gap_reg : gap_reg + TIMER_BITS'(1);
        sil_inc = (sil_reg == TMAX) ? sil_reg : sil_reg + TIMER_BITS'(1);

        rc_inc  = (rc_reg == 9'd511) ? rc_reg : rc_reg + 9'd1;
        diff    = rc_inc - {6'd0, sent_reg};
        fsz     = (diff == 9'd4) ? rx_byte : fs_reg;
        thr     = 10'(sent_reg) + 10'(fsz) + 10'd5;
        bad_inc = (bad_reg == 4'd15) ? bad_reg : bad_reg + 4'd1;

        // unused link code: fresh wake-up
        if (mode_reg != kfi_pkg::LINK_WAKE && mode_reg != kfi_pkg::LINK_OPEN
            && mode_reg != kfi_pkg::LINK_ACTIVE)
        begin
            mode_next = kfi_pkg::LINK_WAKE;
            wake_next = '0;
            low_next  = 1'b0;
            e_x       = '0;
        end

        req_len = (mode_next == kfi_pkg::LINK_OPEN) ? kfi_pkg::START_LEN : kfi_pkg::READ_LEN;
        tx_n    = req_len - sent_reg;

        if (cmd == kfi_pkg::CMD_TICK)
        begin
            if (mode_next == kfi_pkg::LINK_WAKE)
            begin
                if (e_x < b1_x && wake_next != TMAX)
                begin
                    low_next  = 1'b0;
                    wake_next = wake_next + TIMER_BITS'(1);
                end
                else if (e_x < b2_x && wake_next != TMAX)
                begin
                    low_next  = 1'b1;
                    wake_next = wake_next + TIMER_BITS'(1);
                end
                else if (e_x < b3_x && wake_next != TMAX)
                begin
                    low_next  = 1'b0;
                    wake_next = wake_next + TIMER_BITS'(1);
                end
                else
                begin
                    low_next  = 1'b0;
                    sent_next = '0;
                    rc_next   = '0;
                    fs_next   = '0;
                    sum_next  = '0;
                    gap_next  = '0;
                    sil_next  = '0;
                    bst_next  = 1'b0;
                    skip_next = 1'b1;
                    wake_next = '0;
                    mode_next = kfi_pkg::LINK_OPEN;
                end
            end
            else
            begin
                gap_next = gap_inc;
                if (sent_reg < req_len
                    && (skip_reg || XW'(gap_inc) >= XW'(cfg.gap) || gap_inc == TMAX))
                begin
                    for (int j = 0; j < kfi_pkg::MAX_RES; j++)
                    begin
                        if (4'(j) < {1'b0, tx_n})
                        begin
                            res.entry[j].kind = kfi_pkg::KIND_TX;
                            res.entry[j].data = kfi_pkg::req_byte(
                                mode_next == kfi_pkg::LINK_ACTIVE, sent_reg + 3'(j));
                        end
                    end
                    n         = {1'b0, tx_n};
                    sent_next = req_len;
                end
                if (bst_reg)
                begin
                    sil_next = '0;
                    bst_next = 1'b0;
                end
                else
                begin
                    sil_next = sil_inc;
                    if (XW'(sil_inc) > XW'(cfg.watchdog) || sil_inc == TMAX)
                    begin
                        timed     = 1'b1;
                        sent_next = '0;
                        rc_next   = '0;
                        fs_next   = '0;
                        sum_next  = '0;
                        gap_next  = '0;
                        sil_next  = '0;
                        skip_next = 1'b0;
                        bst_next  = 1'b0;
                        if (mode_next == kfi_pkg::LINK_OPEN)
                        begin
                            mode_next = kfi_pkg::LINK_WAKE;
                            wake_next = '0;
                            low_next  = 1'b0;
                        end
                        else
                        begin
                            mode_next = kfi_pkg::LINK_OPEN;
                        end
                    end
                end
            end
        end
        else if (mode_next != kfi_pkg::LINK_WAKE)
        begin
            bst_next = 1'b1;
            rc_next  = rc_inc;
            if (rc_inc > {6'd0, sent_reg})
            begin
                fs_next           = fsz;
                res.entry[0].kind = kfi_pkg::KIND_FRAME;
                res.entry[0].data = rx_byte;
                n                 = 4'd1;
                if ({1'b0, rc_inc} < thr)
                begin
                    sum_next = sum_reg + rx_byte;
                end
                else if ({1'b0, rc_inc} == thr)
                begin
                    good      = (sum_reg == rx_byte);
                    sent_next = '0;
                    rc_next   = '0;
                    fs_next   = '0;
                    sum_next  = '0;
                    gap_next  = '0;
                    sil_next  = '0;
                    skip_next = 1'b0;
                    bst_next  = 1'b0;
                    res.entry[1].kind = good ? kfi_pkg::KIND_GOOD : kfi_pkg::KIND_BAD;
                    res.entry[1].data = 8'h00;
                    n = 4'd2;
                    if (mode_next == kfi_pkg::LINK_OPEN)
                    begin
                        if (good)
                        begin
                            mode_next = kfi_pkg::LINK_ACTIVE;
                        end
                        else
                        begin
                            mode_next = kfi_pkg::LINK_WAKE;
                            wake_next = '0;
                            low_next  = 1'b0;
                        end
                    end
                    else if (good)
                    begin
                        bad_next = '0;
                    end
                    else
                    begin
                        bad_next = bad_inc;
                        if (bad_inc >= cfg.error_limit)
                        begin
                            mode_next = kfi_pkg::LINK_OPEN;
                        end
                    end
                end
            end
        end

        res.entry[n[2:0]].kind = kfi_pkg::KIND_STATUS;
        res.entry[n[2:0]].data = 8'h00;
        res.count      = n + 4'd1;
        res.line_low   = low_next;
        res.link_state = mode_next;
        res.timed_out  = timed;
    end

endmodule

// ===== design/kline_fast_init_polling_client.sv =====
// K-line fast-init polling client.
// Input channel (in_valid/in_stall): one transaction is either a millisecond
// tick (cmd 0) or a received line byte (cmd 1, value on rx_byte).
// Output channel (out_valid/out_stall): each input transaction yields one to
// eight result transactions (transmit bytes, frame bytes, frame end, status);
// the final one of each group is a status result and has last set.
// Config port: cfg_write with cfg_addr/cfg_data, written only while idle
// (a rule for the user; the block does not enforce it). An accepted item is
// held in the input register, evaluated combinationally into the result
// buffer, and offered from there; the buffer then sends one result per clock
// while out_stall is low. An item yields 1 to 8 results, at most 3 for a line
// byte. A new item enters while the previous group drains.
// Reset clears the link to wake-up, all timers and counters, and the config
// registers to their defaults. When the receiver stalls, the current result
// holds; once the input register also holds a waiting item, in_stall rises.
`include "kline_fast_init_polling_client_defines.svh"

module kline_fast_init_polling_client #(
    parameter int TIMER_BITS = kfi_pkg::TIMER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        line_low,
    output logic [1:0]  link_state,
    output logic        timed_out,
    output logic        last
);

    kfi_pkg::cfg_t      cfg_reg;
    logic               in_full_reg;
    logic               cmd_reg;
    logic [7:0]         byte_reg;
    logic               list_valid_reg;
    kfi_pkg::step_res_t list_reg;
    logic [2:0]         idx_reg;
    kfi_pkg::step_res_t step_res;
    logic               advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_idle   <= kfi_pkg::INIT_IDLE_RST;
            cfg_reg.pulse       <= kfi_pkg::PULSE_RST;
            cfg_reg.watchdog    <= kfi_pkg::WATCHDOG_RST;
            cfg_reg.gap         <= kfi_pkg::GAP_RST;
            cfg_reg.error_limit <= kfi_pkg::ERR_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                kfi_pkg::CFG_INIT_IDLE: cfg_reg.init_idle   <= cfg_data;
                kfi_pkg::CFG_PULSE:     cfg_reg.pulse       <= cfg_data[7:0];
                kfi_pkg::CFG_WATCHDOG:  cfg_reg.watchdog    <= cfg_data;
                kfi_pkg::CFG_GAP:       cfg_reg.gap         <= cfg_data;
                kfi_pkg::CFG_ERR_LIMIT: cfg_reg.error_limit <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    assign last      = list_valid_reg && ({1'b0, idx_reg} == list_reg.count - 4'd1);
    assign advance   = in_full_reg && (!list_valid_reg || (!out_stall && last));
    assign in_stall  = in_full_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
    end

    kfi_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (cmd_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (advance)
        begin
            list_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (list_valid_reg && !out_stall)
        begin
            if (last)
            begin
                list_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            list_reg <= step_res;
        end
    end

    assign out_valid  = list_valid_reg;
    assign kind       = list_reg.entry[idx_reg].kind;
    assign data_byte  = list_reg.entry[idx_reg].data;
    assign line_low   = list_reg.line_low;
    assign link_state = list_reg.link_state;
    assign timed_out  = list_reg.timed_out;

    `KFI_ASSERT_IMPL(a_idx_in_range, list_valid_reg, {1'b0, idx_reg} < list_reg.count, "result index past group end")
    `KFI_ASSERT_IMPL(a_last_is_status, last, kind == kfi_pkg::KIND_STATUS, "group does not end with status")
    `KFI_ASSERT_NEXT(a_advance_loads, advance, list_valid_reg && idx_reg == 3'd0, "result group not loaded")
    `KFI_ASSERT_IMPL(a_low_only_wake, list_valid_reg && line_low, link_state == kfi_pkg::LINK_WAKE, "line low outside wake-up")
    `KFI_ASSERT_IMPL(a_timeout_state, list_valid_reg && timed_out, link_state != kfi_pkg::LINK_ACTIVE, "timeout left link active")

endmodule
